[rtl/swmm_pkg.sv]
`timescale 1ns / 1ps
package swmm_pkg;
  typedef enum logic [1:0] {
    CFG_USE_WINDOW    = 2'd0,
    CFG_WINDOW_LENGTH = 2'd1
  } cfg_idx_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;
endpackage

[rtl/sliding_window_minmax_normaliser.sv]
`timescale 1ns / 1ps
// Sliding-window min/max normaliser.
// Input beats carry one signed sample on in_sample, taken when in_valid is
// high and in_stall low. Each input beat yields one output beat: out_normalised
// is the sample scaled into 0..1 as unsigned Q1.15, out_flat_range flags a
// zero range (the value is then 0).
// In window mode the front stage writes the sample into a ring memory and
// scans the window one entry a cycle; running mode skips the memory and the
// scan and keeps running bounds instead. The back stage takes the job, runs
// a restoring divide and presents the result; the divide is skipped when
// the range is flat or the sample sits at the maximum.
// A two-entry queue between them overlaps the scan of one beat with the
// divide of the previous one, so the front can take a new sample while the
// back is still busy with an earlier one.
// Configuration writes (cfg_valid/cfg_ready, always ready) select mode
// (index 0) and window length (index 1); a length write restarts the window.
// Reset is synchronous, active low; it restores window mode, length 64 and
// clears the running bounds. A stalled output beat holds its value, and the
// queue then fills and backs up into in_stall.
module sliding_window_minmax_normaliser import swmm_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_normalised,
  output logic        out_flat_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LW = $clog2(WINDOW_DEPTH + 1);

  logic use_window_r;
  logic [6:0] win_len_r;
  logic [LW-1:0] eff_len;
  logic len_wr;
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  assign cfg_ready = 1'b1;
  assign len_wr = cfg_valid && (cfg_index == 1'(CFG_WINDOW_LENGTH));

  always_comb begin
    if (win_len_r == '0) eff_len = LW'(1);
    else if (32'(win_len_r) > WINDOW_DEPTH) eff_len = LW'(WINDOW_DEPTH);
    else eff_len = LW'(win_len_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_window_r <= 1'b1;
      win_len_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == 1'(CFG_USE_WINDOW)) use_window_r <= cfg_data[0];
      else win_len_r <= cfg_data;
    end
  end

  swmm_front #(.DEPTH(WINDOW_DEPTH), .LW(LW), .PW(PW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample(signed'(in_sample)),
    .use_window(use_window_r), .eff_len, .len_wr,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  swmm_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  swmm_back u_back (
    .clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_stall, .out_normalised, .out_flat_range
  );

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flat_range |-> out_normalised == 16'd0)
    else $error("flat range with nonzero result");
  a_norm_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normalised <= 16'h8000)
    else $error("result above one");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_normalised))
    else $error("stalled result changed");
endmodule

[rtl/swmm_front.sv]
`timescale 1ns / 1ps
module swmm_front import swmm_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int LW    = 7,
  parameter int PW    = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               use_window,
  input  logic [LW-1:0]      eff_len,
  input  logic               len_wr,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);
  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_data_r;
  front_state_t state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt, idx_r, idx_nxt;
  logic [LW-1:0] fill_r, fill_nxt, cnt_r, cnt_nxt;
  logic signed [15:0] s_r, s_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [15:0] rmin_r, rmin_nxt, rmax_r, rmax_nxt;
  logic first_r, first_nxt;
  logic [PW-1:0] len_m1, wp_use, wp_inc;
  logic wr_en;

  assign len_m1 = PW'(eff_len - LW'(1));
  assign wp_use = (LW'(wp_r) >= eff_len) ? '0 : wp_r;
  assign wp_inc = (wp_use == len_m1) ? '0 : wp_use + PW'(1);
  assign in_stall = (state_r != F_IDLE);
  assign wr_en = in_valid && !in_stall && use_window;
  assign job_valid = (state_r == F_PUSH);
  assign job = '{sample: s_r, lo: lo_r, hi: hi_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_use] <= in_sample;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      rmin_r  <= '0;
      rmax_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      rmin_r  <= rmin_nxt;
      rmax_r  <= rmax_nxt;
    end
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    s_r     <= s_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    first_r <= first_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt = wp_r;
    fill_nxt = fill_r;
    rmin_nxt = rmin_r;
    rmax_nxt = rmax_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    s_nxt = s_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    first_nxt = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          s_nxt = in_sample;
          if (use_window) begin
            wp_nxt = wp_inc;
            fill_nxt = (fill_r < eff_len) ? fill_r + LW'(1) : eff_len;
            // The new sample is the newest entry; the scan covers the rest.
            cnt_nxt = ((fill_r < eff_len) ? fill_r + LW'(1) : eff_len) - LW'(1);
            idx_nxt = (wp_use == '0) ? len_m1 : wp_use - PW'(1);
            lo_nxt = in_sample;
            hi_nxt = in_sample;
            first_nxt = 1'b1;
            state_nxt = F_SCAN;
          end else begin
            rmin_nxt = (in_sample < rmin_r) ? in_sample : rmin_r;
            rmax_nxt = (in_sample > rmax_r) ? in_sample : rmax_r;
            lo_nxt = rmin_nxt;
            hi_nxt = rmax_nxt;
            state_nxt = F_PUSH;
          end
        end
      end
      F_SCAN: begin
        // Read data is registered behind the address, so the first scan cycle only primes it.
        if (!first_r) begin
          if (rd_data_r < lo_r) lo_nxt = rd_data_r;
          if (rd_data_r > hi_r) hi_nxt = rd_data_r;
        end
        if (cnt_r == '0) begin
          state_nxt = F_PUSH;
        end else begin
          cnt_nxt = cnt_r - LW'(1);
          idx_nxt = (idx_r == '0) ? len_m1 : idx_r - PW'(1);
        end
      end
      F_PUSH: begin
        if (job_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
    if (len_wr) begin
      wp_nxt = '0;
      fill_nxt = '0;
    end
  end
endmodule

[rtl/swmm_queue.sv]
`timescale 1ns / 1ps
module swmm_queue import swmm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t slot_r [2];
  logic rp_r, wp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = slot_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= 1'b0;
      wp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot_r[wp_r] <= wr_data;
  end
endmodule

[rtl/swmm_back.sv]
`timescale 1ns / 1ps
module swmm_back import swmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_normalised,
  output logic        out_flat_range
);
  back_state_t state_r, state_nxt;
  logic [16:0] range_r, range_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [4:0] step_r, step_nxt;
  logic [15:0] norm_r, norm_nxt;
  logic flat_r, flat_nxt;
  logic [16:0] diff, rng;
  logic [32:0] trial;

  assign diff = 17'($signed({job.sample[15], job.sample}) - $signed({job.lo[15], job.lo}));
  assign rng  = 17'($signed({job.hi[15], job.hi}) - $signed({job.lo[15], job.lo}));
  assign trial = {rem_r[31:0], 1'b0};
  assign job_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_normalised = norm_r;
  assign out_flat_range = flat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
    range_r <= range_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    step_r <= step_nxt;
    norm_r <= norm_nxt;
    flat_r <= flat_nxt;
  end

  // Restoring divide of diff*32768 by range, one quotient bit a cycle.
  // Since diff < range here, the quotient fits the 15 bits below the integer bit.
  always_comb begin
    state_nxt = state_r;
    range_nxt = range_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    step_nxt = step_r;
    norm_nxt = norm_r;
    flat_nxt = flat_r;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          range_nxt = rng;
          flat_nxt = (rng == '0);
          if (rng == '0) begin
            norm_nxt = '0;
            state_nxt = B_OUT;
          end else if (diff == rng) begin
            norm_nxt = 16'h8000;
            state_nxt = B_OUT;
          end else begin
            rem_nxt = {16'd0, diff};
            quo_nxt = '0;
            step_nxt = 5'd15;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (trial >= {16'd0, range_r}) begin
          rem_nxt = trial - {16'd0, range_r};
          quo_nxt = {quo_r[14:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[14:0], 1'b0};
        end
        if (step_r == 5'd1) begin
          norm_nxt = quo_nxt;
          state_nxt = B_OUT;
        end else begin
          step_nxt = step_r - 5'd1;
        end
      end
      B_OUT: begin
        if (!out_stall) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import swmm_pkg::*;

  localparam int DEPTH       = 64;
  localparam int DRAIN_WAIT  = 100;
  localparam int STALL_LIMIT = 20000;

  typedef enum int { ROW_SAMPLE, ROW_MODE, ROW_LENGTH } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;
    bit          typed;
    logic [15:0] norm;
    logic        flat;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_normalised;
  logic        out_flat_range;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_data;

  sliding_window_minmax_normaliser u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_normalised(out_normalised),
    .out_flat_range(out_flat_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the normaliser state.
  logic signed [15:0] ring [DEPTH];
  int unsigned        ring_wr;
  int unsigned        ring_fill;
  logic signed [15:0] run_lo;
  logic signed [15:0] run_hi;
  logic               mode_window;
  logic [6:0]         len_reg;

  logic [16:0] scaled_q [$];   // {flat, normalised} per pending output beat
  int          mismatches;
  int          in_idle_pct;
  int          out_stall_pct;
  int          hold_cycles;
  bit          row_typed;
  logic [15:0] row_norm;
  logic        row_flat;

  function automatic int unsigned window_len();
    if (len_reg < 1) return 1;
    if (len_reg > DEPTH) return DEPTH;
    return len_reg;
  endfunction

  function automatic logic [16:0] normalise_sample(input logic [15:0] raw);
    logic signed [15:0] s;
    int                 lo;
    int                 hi;
    int unsigned        len;
    int unsigned        wp;
    int unsigned        idx;
    int unsigned        range;
    int unsigned        res;
    s = raw;
    if (mode_window) begin
      len = window_len();
      wp = ring_wr;
      if (wp >= len) wp = 0;
      ring[wp] = s;
      wp++;
      if (wp >= len) wp = 0;
      ring_wr = wp;
      if (ring_fill < len) ring_fill++;
      if (ring_fill > len) ring_fill = len;
      lo = s;
      hi = s;
      idx = wp;
      for (int i = 0; i < ring_fill; i++) begin
        idx = (idx == 0) ? len - 1 : idx - 1;
        if (ring[idx] < lo) lo = ring[idx];
        if (ring[idx] > hi) hi = ring[idx];
      end
    end else begin
      if (s < run_lo) run_lo = s;
      if (s > run_hi) run_hi = s;
      lo = run_lo;
      hi = run_hi;
    end
    range = hi - lo;
    if (range == 0) return {1'b1, 16'd0};
    res = (int'(s) - lo) * 32768 / range;
    if (res > 32768) res = 32768;
    return {1'b0, res[15:0]};
  endfunction

  // Input monitor: every accepted sample produces one expected output beat.
  always @(posedge clk) begin : p_input_mon
    logic [16:0] e;
    if (rst_n && in_valid && !in_stall) begin
      e = normalise_sample(in_sample);
      if (row_typed) e = {row_flat, row_norm};
      scaled_q.push_back(e);
    end
  end

  always @(posedge clk) begin : p_output_chk
    logic [16:0] e;
    if (rst_n && out_valid && !out_stall) begin
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output beat: norm=%0d flat=%0b", out_normalised, out_flat_range);
      end else begin
        e = scaled_q.pop_front();
        if (out_normalised !== e[15:0] || out_flat_range !== e[16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected norm=%0d flat=%0b, got norm=%0d flat=%0b",
                     $time, e[15:0], e[16], out_normalised, out_flat_range);
        end
      end
    end
  end

  // Result side: random stall, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin : p_watchdog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (scaled_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [6:0] value);
    in_valid = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_index = idx[0:0];
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_USE_WINDOW) begin
      mode_window = value[0];
    end else begin
      len_reg   = value;
      ring_fill = 0;
      ring_wr   = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] s, input bit typed,
                             input logic [15:0] norm, input logic flat);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    row_typed = typed;
    row_norm  = norm;
    row_flat  = flat;
    in_sample = s;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [6:0] pick_length();
    case ($urandom_range(9))
      0:       return 7'd1;
      1:       return 7'd0;
      2:       return 7'd64;
      3:       return 7'($urandom_range(127));
      default: return 7'($urandom_range(8, 1));
    endcase
  endfunction

  stim_row_t directed [] = '{
    '{ROW_SAMPLE, 16'h7FFF, 1, 16'd0,     1'b1},
    '{ROW_SAMPLE, 16'h8000, 1, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h7FFF, 1, 16'd32768, 1'b0},
    '{ROW_SAMPLE, 16'h0000, 0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'hFFFF, 0, 16'd0,     1'b0},
    '{ROW_LENGTH, 16'd1,    0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h1234, 1, 16'd0,     1'b1},
    '{ROW_SAMPLE, 16'h8000, 1, 16'd0,     1'b1},
    '{ROW_LENGTH, 16'd0,    0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h7FFF, 1, 16'd0,     1'b1},
    '{ROW_LENGTH, 16'd3,    0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'd10,   0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'd20,   0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'd15,   0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'd30,   0, 16'd0,     1'b0},
    '{ROW_LENGTH, 16'd127,  0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h5555, 0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'hAAAA, 0, 16'd0,     1'b0},
    '{ROW_MODE,   16'd0,    0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h0000, 1, 16'd0,     1'b1},
    '{ROW_SAMPLE, 16'd100,  1, 16'd32768, 1'b0},
    '{ROW_SAMPLE, 16'hFF9C, 1, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h7FFF, 0, 16'd0,     1'b0},
    '{ROW_SAMPLE, 16'h8000, 0, 16'd0,     1'b0},
    '{ROW_MODE,   16'd1,    0, 16'd0,     1'b0}
  };

  initial begin : p_main
    int          base;
    logic [15:0] s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    row_typed = 0;
    row_norm = '0;
    row_flat = 1'b0;
    foreach (ring[i]) ring[i] = '0;
    ring_wr = 0;
    ring_fill = 0;
    run_lo = '0;
    run_hi = '0;
    mode_window = 1'b1;
    len_reg = 7'd64;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_SAMPLE: send_sample(directed[i].value, directed[i].typed,
                                directed[i].norm, directed[i].flat);
        ROW_MODE:   write_reg(CFG_USE_WINDOW, directed[i].value[6:0]);
        default:    write_reg(CFG_WINDOW_LENGTH, directed[i].value[6:0]);
      endcase
    end
    in_valid = 1'b0;

    // Fill the pipeline against a long receiver hold-off.
    write_reg(CFG_WINDOW_LENGTH, 7'd4);
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) send_sample(16'($urandom_range(65535)), 0, '0, 1'b0);
    in_valid = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 86; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 86; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      base = $urandom_range(65535);
      for (int i = 0; i < 160; i++) begin
        if (i % 20 == 0) begin
          write_reg(CFG_USE_WINDOW, 7'($urandom_range(3) != 0));
          write_reg(CFG_WINDOW_LENGTH, pick_length());
          base = $urandom_range(65535);
        end
        if (i == 90) begin
          in_valid = 1'b0;
          wait_drained();
        end
        case ($urandom_range(9))
          0:       s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          1, 2, 3: s = 16'($urandom_range(65535));
          default: s = 16'(base + int'($urandom_range(64)) - 32);
        endcase
        send_sample(s, 0, '0, 1'b0);
      end
      in_valid = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0 && scaled_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[files.f]
rtl/swmm_pkg.sv
rtl/swmm_front.sv
rtl/swmm_queue.sv
rtl/swmm_back.sv
rtl/sliding_window_minmax_normaliser.sv
verif/tb_top.sv
